// ===== hdl/gad_pkg.sv =====
`default_nettype none

package gad_pkg;

	localparam int MAX_STEPS        = 48;
	localparam int CORDIC_STEPS_DEF = 32;
	localparam int FRAC             = 58;
	localparam int STEP_W           = $clog2(MAX_STEPS);

	// pi * 2^90, truncated, and the factor from 1e-7 degree to radians in Q90.
	localparam logic [127:0] PI_2_90 = 128'h0C90FDAA_22168C23_4C4C6628;
	localparam logic [63:0]  DEG_K   = 64'(PI_2_90 / 128'd1800000000);

	localparam logic [63:0] ONE_Q58    = 64'h0400_0000_0000_0000;
	localparam logic [63:0] PI_QUARTER = 64'h0324_3F6A_8885_A309;
	localparam logic [63:0] TWO_R_CM   = 64'd1274200000;
	localparam logic [63:0] DIST_MAX   = 64'd2001508680;

	localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;
	localparam logic signed [33:0] HALF_TURN = 34'sd1800000000;
	localparam logic signed [33:0] FULL_TURN = 34'sd3600000000;

	localparam logic [30:0] THRESHOLD_RST = 31'd2000;

	typedef enum logic [1:0] {
		ST_WAIT_FIX  = 2'd0,
		ST_WAIT_DEST = 2'd1,
		ST_EN_ROUTE  = 2'd2,
		ST_ARRIVED   = 2'd3
	} nav_status_t;

	typedef enum logic [1:0] {
		CFG_DEST_LAT  = 2'd0,
		CFG_DEST_LON  = 2'd1,
		CFG_THRESHOLD = 2'd2
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PREP  = 5'b00010,
		S_ISSUE = 5'b00100,
		S_WAIT  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	// Micro-steps of the sequencer, one unit operation each.
	typedef enum logic [4:0] {
		MS_TH0  = 5'd0,
		MS_ROT0 = 5'd1,
		MS_C0   = 5'd2,
		MS_S0   = 5'd3,
		MS_TH1  = 5'd4,
		MS_ROT1 = 5'd5,
		MS_C1   = 5'd6,
		MS_S1   = 5'd7,
		MS_TH2  = 5'd8,
		MS_ROT2 = 5'd9,
		MS_C2   = 5'd10,
		MS_S2   = 5'd11,
		MS_PA   = 5'd12,
		MS_QA   = 5'd13,
		MS_VA   = 5'd14,
		MS_PB   = 5'd15,
		MS_QB   = 5'd16,
		MS_VB   = 5'd17,
		MS_VZ   = 5'd18,
		MS_DIV  = 5'd19,
		MS_DIST = 5'd20
	} ms_t;

	typedef struct packed {
		logic start;
		logic vectoring;
	} cor_ctl_t;

	typedef logic [63:0] atan_tab_t [MAX_STEPS];

	// Long division by repeated subtraction, for building constants only.
	function automatic logic [63:0] udiv_c(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(2^-i) in Q58: pi/4 for i = 0, else from its power series, each term rounded to nearest.
	function automatic logic [63:0] atan_entry(input int i);
		logic [63:0] sum;
		logic [63:0] t;
		int e;
		sum = '0;
		if (i == 0) begin
			sum = PI_QUARTER;
		end else begin
			for (int k = 0; k < 30; k++) begin
				e = FRAC - i * (2 * k + 1);
				if (e >= 0) begin
					t = udiv_c((64'd1 << e) + 64'(k), 64'(2 * k + 1));
					if ((k & 1) != 0)
						sum = sum - t;
					else
						sum = sum + t;
				end
			end
		end
		return sum;
	endfunction

	function automatic atan_tab_t build_atan();
		atan_tab_t tab;
		for (int i = 0; i < MAX_STEPS; i++)
			tab[i] = atan_entry(i);
		return tab;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();

endpackage

`default_nettype wire

// ===== hdl/gad_if.sv =====
`default_nettype none

interface gad_fix_if;
	logic               valid;
	logic               ready;
	logic signed [30:0] fix_latitude;
	logic signed [31:0] fix_longitude;
	modport source (output valid, fix_latitude, fix_longitude, input ready);
	modport sink (input valid, fix_latitude, fix_longitude, output ready);
endinterface

interface gad_res_if;
	logic        valid;
	logic        ready;
	logic [30:0] distance_cm;
	logic [1:0]  nav_status;
	logic        stop_request;
	logic        arrival_event;
	modport source (output valid, distance_cm, nav_status, stop_request, arrival_event,
		input ready);
	modport sink (input valid, distance_cm, nav_status, stop_request, arrival_event,
		output ready);
endinterface

interface gad_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/gad_mul.sv =====
`default_nettype none

// Unsigned 64 x 64 shift-and-add multiplier, one multiplier bit per cycle.
module gad_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [127:0] prod,
	output logic         done
);

	localparam logic [5:0] LAST = 6'd63;

	logic [63:0] a_q, b_q, hi_q, lo_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] sum;

	always_comb begin
		sum = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : 65'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			hi_q <= sum[64:1];
			lo_q <= {sum[0], lo_q[63:1]};
			b_q  <= {1'b0, b_q[63:1]};
		end
	end

	assign prod = {hi_q, lo_q};
	assign done = done_q;

endmodule

`default_nettype wire

// ===== hdl/gad_div.sv =====
`default_nettype none

// Restoring divider of a 128-bit dividend by a 64-bit divisor, one quotient
// bit per cycle. The upper half must be below the divisor.
module gad_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num_hi,
	input  logic [63:0] num_lo,
	input  logic [63:0] den,
	output logic [63:0] quot,
	output logic        done
);

	localparam logic [5:0] LAST = 6'd63;

	logic [63:0] r_q, lo_q, den_q, q_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [63:0] rs, diff;
	logic        take;

	always_comb begin
		rs   = {r_q[62:0], lo_q[63]};
		diff = rs - den_q;
		// A bit shifted out of the top means the remainder already exceeds the divisor.
		take = r_q[63] || (rs >= den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= num_hi;
			lo_q  <= num_lo;
			den_q <= den;
			q_q   <= '0;
		end else if (busy_q) begin
			r_q  <= take ? diff : rs;
			lo_q <= {lo_q[62:0], 1'b0};
			q_q  <= {q_q[62:0], take};
		end
	end

	assign quot = q_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== hdl/gad_cordic.sv =====
`default_nettype none

// Circular CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
module gad_cordic #(
	parameter int STEPS = gad_pkg::CORDIC_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gad_pkg::cor_ctl_t       ctl,
	input  logic signed [63:0]      x0,
	input  logic signed [63:0]      y0,
	input  logic signed [63:0]      z0,
	output logic signed [63:0]      x,
	output logic signed [63:0]      y,
	output logic signed [63:0]      z,
	output logic                    done
);

	localparam int N = (STEPS > gad_pkg::MAX_STEPS) ? gad_pkg::MAX_STEPS : STEPS;
	localparam logic [gad_pkg::STEP_W-1:0] LAST = gad_pkg::STEP_W'(N - 1);

	logic signed [63:0]         x_q, y_q, z_q;
	logic [gad_pkg::STEP_W-1:0] cnt_q;
	logic                       busy_q, done_q, vec_q;
	logic signed [63:0]         dx, dy, ang;
	logic                       up;

	always_comb begin
		dx  = y_q >>> cnt_q;
		dy  = x_q >>> cnt_q;
		ang = $signed(gad_pkg::ATAN_TAB[cnt_q]);
		// Vectoring drives y towards zero, rotation drives z towards zero.
		up  = vec_q ? (y_q > 64'sd0) : (z_q < 64'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q   <= x0;
			y_q   <= y0;
			z_q   <= z0;
			vec_q <= ctl.vectoring;
		end else if (busy_q) begin
			if (up) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end
		end
	end

	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== hdl/gnss_arrival_distance_core.sv =====
// Channel  Dir  Handshake      Payload
// fix      in   valid/ready    fix_latitude[30:0] s, fix_longitude[31:0] s
// res      out  valid/ready    distance_cm[30:0], nav_status[1:0], stop_request,
//                              arrival_event
// cfg      in   valid/ready    index[1:0], data[31:0]; ready is always high
//
// For a fix with a valid destination the serial multiplier, one bit per cycle over
// 64 bits, sets most of the work time; the divide is skipped when the last
// vectoring gives an x that is not positive or a |y| >> 6 not below x. A
// waiting fix skips the arithmetic units.
// One fix is worked on at a time; the next is taken once the result is in the
// output register, which holds it while the sink stalls.
// Reset clears the destination, the reached flag and the output valid, and sets
// the threshold to 2000 cm.
`default_nettype none

module gnss_arrival_distance_core #(
	parameter int CORDIC_STEPS = gad_pkg::CORDIC_STEPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gad_fix_if.sink   fix,
	gad_res_if.source res,
	gad_cfg_if.sink   cfg
);

	gad_pkg::state_t state_q;
	gad_pkg::ms_t    pc_q;

	logic signed [30:0] flat_q, dlat_q;
	logic signed [31:0] flon_q, dlon_q;
	logic [30:0]        thr_q;
	logic               reached_q;
	logic [32:0]        u0_q, u1_q, u2_q;
	logic               waitfix_q, waitdest_q, neg_q;
	logic signed [63:0] t_q, c1_q, s1_q, c2_q, s2_q, c3_q, s3_q;
	logic signed [63:0] p_q, q_q, ha_q, hb_q, z_q;
	logic [30:0]        dist_q;

	logic        out_valid_q;
	logic [30:0] out_dist_q;
	logic [1:0]  out_status_q;
	logic        out_stop_q, out_event_q;

	// Angle preparation.
	logic signed [30:0] flat_c, dlat_c;
	logic signed [33:0] dphi, sphi, dlam, dlam_w;
	logic signed [33:0] adphi, asphi, adlam;
	logic               fix_zero, dest_zero;

	always_comb begin
		if (flat_q > gad_pkg::LAT_LIMIT)
			flat_c = gad_pkg::LAT_LIMIT;
		else if (flat_q < -gad_pkg::LAT_LIMIT)
			flat_c = -gad_pkg::LAT_LIMIT;
		else
			flat_c = flat_q;
		if (dlat_q > gad_pkg::LAT_LIMIT)
			dlat_c = gad_pkg::LAT_LIMIT;
		else if (dlat_q < -gad_pkg::LAT_LIMIT)
			dlat_c = -gad_pkg::LAT_LIMIT;
		else
			dlat_c = dlat_q;
		dphi = 34'(dlat_c) - 34'(flat_c);
		sphi = 34'(dlat_c) + 34'(flat_c);
		dlam = 34'(dlon_q) - 34'(flon_q);
		if (dlam > gad_pkg::HALF_TURN)
			dlam_w = dlam - gad_pkg::FULL_TURN;
		else if (dlam < -gad_pkg::HALF_TURN)
			dlam_w = dlam + gad_pkg::FULL_TURN;
		else
			dlam_w = dlam;
		adphi = dphi[33] ? -dphi : dphi;
		asphi = sphi[33] ? -sphi : sphi;
		adlam = dlam_w[33] ? -dlam_w : dlam_w;
		fix_zero  = (flat_q == 31'sd0) && (flon_q == 32'sd0);
		dest_zero = (dlat_q == 31'sd0) && (dlon_q == 32'sd0);
	end

	// Unit selection for the current micro-step.
	logic is_rot, is_vec, is_div;

	always_comb begin
		is_rot = pc_q inside {gad_pkg::MS_ROT0, gad_pkg::MS_ROT1, gad_pkg::MS_ROT2};
		is_vec = pc_q inside {gad_pkg::MS_VA, gad_pkg::MS_VB, gad_pkg::MS_VZ};
		is_div = (pc_q == gad_pkg::MS_DIV);
	end

	// Multiplier operands, signed; the unit sees magnitudes.
	logic signed [63:0] ma, mb;
	logic [63:0]        ma_abs, mb_abs;
	logic               m_neg;
	logic [127:0]       prod;
	logic               mul_done, mul_start;
	logic signed [63:0] cor_x, cor_y, cor_z;

	always_comb begin
		ma = '0;
		mb = '0;
		case (pc_q)
			gad_pkg::MS_TH0: begin
				ma = 64'(u0_q);
				mb = gad_pkg::DEG_K;
			end
			gad_pkg::MS_TH1: begin
				ma = 64'(u1_q);
				mb = gad_pkg::DEG_K;
			end
			gad_pkg::MS_TH2: begin
				ma = 64'(u2_q);
				mb = gad_pkg::DEG_K;
			end
			gad_pkg::MS_C0, gad_pkg::MS_C1, gad_pkg::MS_C2: begin
				ma = cor_y;
				mb = cor_z;
			end
			gad_pkg::MS_S0, gad_pkg::MS_S1, gad_pkg::MS_S2: begin
				ma = cor_x;
				mb = cor_z;
			end
			gad_pkg::MS_PA: begin
				ma = s1_q;
				mb = c2_q;
			end
			gad_pkg::MS_QA: begin
				ma = c3_q;
				mb = s2_q;
			end
			gad_pkg::MS_PB: begin
				ma = c1_q;
				mb = c2_q;
			end
			gad_pkg::MS_QB: begin
				ma = s3_q;
				mb = s2_q;
			end
			gad_pkg::MS_DIST: begin
				ma = z_q;
				mb = gad_pkg::TWO_R_CM;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		ma_abs = ma[63] ? -ma : ma;
		mb_abs = mb[63] ? -mb : mb;
		m_neg  = ma[63] ^ mb[63];
	end

	assign mul_start = (state_q == gad_pkg::S_ISSUE) && !is_rot && !is_vec && !is_div;

	gad_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (ma_abs),
		.b      (mb_abs),
		.prod   (prod),
		.done   (mul_done)
	);

	// CORDIC.
	gad_pkg::cor_ctl_t  cor_ctl;
	logic signed [63:0] cx0, cy0, cz0;
	logic               cor_done;

	always_comb begin
		cor_ctl.start     = (state_q == gad_pkg::S_ISSUE) && (is_rot || is_vec);
		cor_ctl.vectoring = is_vec;
		cx0 = '0;
		cy0 = '0;
		cz0 = '0;
		if (is_rot) begin
			cx0 = gad_pkg::ONE_Q58;
			cz0 = t_q;
		end else if (pc_q == gad_pkg::MS_VZ) begin
			cx0 = hb_q;
			cy0 = ha_q;
		end else begin
			cx0 = p_q;
			cy0 = q_q;
		end
	end

	gad_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cor_ctl),
		.x0     (cx0),
		.y0     (cy0),
		.z0     (cz0),
		.x      (cor_x),
		.y      (cor_y),
		.z      (cor_z),
		.done   (cor_done)
	);

	// Residual angle of the last vectoring: |y| * 2^58 / x.
	logic [63:0] uy, quot;
	logic        div_cond, div_start, div_done;

	always_comb begin
		uy       = cor_y[63] ? -cor_y : cor_y;
		div_cond = (cor_x > 64'sd0) && ((uy >> 6) < $unsigned(cor_x));
	end

	assign div_start = (state_q == gad_pkg::S_ISSUE) && is_div && div_cond;

	gad_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_hi (uy >> 6),
		.num_lo (uy << 58),
		.den    ($unsigned(cor_x)),
		.quot   (quot),
		.done   (div_done)
	);

	// Write-back values.
	logic [63:0]        rnd58, th;
	logic signed [63:0] mq, mq_abs, zdiv, zdiv_c, cz_c;
	logic               unit_done;

	always_comb begin
		rnd58  = prod[121:58] + 64'(prod[57]);
		th     = prod[96:33] + 64'(prod[32]);
		mq     = neg_q ? -rnd58 : rnd58;
		mq_abs = mq[63] ? -mq : mq;
		zdiv   = cor_y[63] ? (cor_z - $signed(quot)) : (cor_z + $signed(quot));
		zdiv_c = zdiv[63] ? 64'sd0 : zdiv;
		cz_c   = cor_z[63] ? 64'sd0 : cor_z;
		if (is_div)
			unit_done = div_done;
		else if (is_rot || is_vec)
			unit_done = cor_done;
		else
			unit_done = mul_done;
	end

	// Result of the current item.
	gad_pkg::nav_status_t st;
	logic                 ev, out_load;

	always_comb begin
		ev = 1'b0;
		if (waitfix_q)
			st = gad_pkg::ST_WAIT_FIX;
		else if (waitdest_q)
			st = gad_pkg::ST_WAIT_DEST;
		else if (dist_q < thr_q) begin
			st = gad_pkg::ST_ARRIVED;
			ev = !reached_q;
		end else
			st = gad_pkg::ST_EN_ROUTE;
		out_load = (state_q == gad_pkg::S_DONE) && (!out_valid_q || res.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gad_pkg::S_IDLE;
			pc_q        <= gad_pkg::MS_TH0;
			out_valid_q <= 1'b0;
			reached_q   <= 1'b0;
			dlat_q      <= '0;
			dlon_q      <= '0;
			thr_q       <= gad_pkg::THRESHOLD_RST;
		end else begin
			if (cfg.valid) begin
				case (gad_pkg::cfg_idx_t'(cfg.index))
					gad_pkg::CFG_DEST_LAT: begin
						dlat_q    <= cfg.data[30:0];
						reached_q <= 1'b0;
					end
					gad_pkg::CFG_DEST_LON: begin
						dlon_q    <= cfg.data;
						reached_q <= 1'b0;
					end
					gad_pkg::CFG_THRESHOLD: thr_q <= cfg.data[30:0];
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				gad_pkg::S_IDLE: begin
					if (fix.valid)
						state_q <= gad_pkg::S_PREP;
				end
				gad_pkg::S_PREP: begin
					pc_q <= gad_pkg::MS_TH0;
					if (fix_zero || dest_zero)
						state_q <= gad_pkg::S_DONE;
					else
						state_q <= gad_pkg::S_ISSUE;
				end
				gad_pkg::S_ISSUE: begin
					// If x <= 0 or |y| >> 6 >= x, the divide is skipped and the step completes at once.
					if (is_div && !div_cond)
						pc_q <= gad_pkg::MS_DIST;
					else
						state_q <= gad_pkg::S_WAIT;
				end
				gad_pkg::S_WAIT: begin
					if (unit_done) begin
						if (pc_q == gad_pkg::MS_DIST)
							state_q <= gad_pkg::S_DONE;
						else begin
							pc_q    <= gad_pkg::ms_t'(5'(pc_q) + 5'd1);
							state_q <= gad_pkg::S_ISSUE;
						end
					end
				end
				gad_pkg::S_DONE: begin
					if (out_load) begin
						state_q <= gad_pkg::S_IDLE;
						if (st == gad_pkg::ST_ARRIVED)
							reached_q <= 1'b1;
					end
				end
				default: state_q <= gad_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == gad_pkg::S_IDLE) && fix.valid) begin
			flat_q <= fix.fix_latitude;
			flon_q <= fix.fix_longitude;
		end
		if (state_q == gad_pkg::S_PREP) begin
			u0_q       <= adphi[32:0];
			u1_q       <= adlam[32:0];
			u2_q       <= asphi[32:0];
			waitfix_q  <= fix_zero;
			waitdest_q <= dest_zero;
			dist_q     <= '0;
		end
		if (state_q == gad_pkg::S_ISSUE) begin
			neg_q <= m_neg;
			if (is_div && !div_cond)
				z_q <= cz_c;
		end
		if ((state_q == gad_pkg::S_WAIT) && unit_done) begin
			case (pc_q)
				gad_pkg::MS_TH0, gad_pkg::MS_TH1, gad_pkg::MS_TH2: t_q <= th;
				gad_pkg::MS_C0: c1_q <= cor_x - mq;
				gad_pkg::MS_S0: s1_q <= cor_y + mq;
				gad_pkg::MS_C1: c2_q <= cor_x - mq;
				gad_pkg::MS_S1: s2_q <= cor_y + mq;
				gad_pkg::MS_C2: c3_q <= cor_x - mq;
				gad_pkg::MS_S2: s3_q <= cor_y + mq;
				gad_pkg::MS_PA, gad_pkg::MS_PB: p_q <= mq_abs;
				gad_pkg::MS_QA, gad_pkg::MS_QB: q_q <= mq_abs;
				gad_pkg::MS_VA: ha_q <= cor_x;
				gad_pkg::MS_VB: hb_q <= cor_x;
				gad_pkg::MS_DIV: z_q <= zdiv_c;
				gad_pkg::MS_DIST:
					dist_q <= (rnd58 > gad_pkg::DIST_MAX) ? gad_pkg::DIST_MAX[30:0]
						: rnd58[30:0];
				default: ;
			endcase
		end
		if (out_load) begin
			out_dist_q   <= dist_q;
			out_status_q <= st;
			out_stop_q   <= (st != gad_pkg::ST_EN_ROUTE);
			out_event_q  <= ev;
		end
	end

	assign fix.ready         = (state_q == gad_pkg::S_IDLE);
	assign cfg.ready         = 1'b1;
	assign res.valid         = out_valid_q;
	assign res.distance_cm   = out_dist_q;
	assign res.nav_status    = out_status_q;
	assign res.stop_request  = out_stop_q;
	assign res.arrival_event = out_event_q;

endmodule

`default_nettype wire

// ===== hdl/gad_checker.sv =====
`default_nettype none

module gad_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [30:0] distance_cm,
	input logic [1:0]  nav_status,
	input logic        stop_request,
	input logic        arrival_event
);

	// A stalled result item stays put.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(distance_cm)
			&& $stable(nav_status) && $stable(arrival_event))
		else $error("result item changed while stalled");

	// Only en route lets the vehicle move.
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (stop_request == (nav_status != gad_pkg::ST_EN_ROUTE)))
		else $error("stop request does not match status");

	// The arrival event comes only with the arrived status.
	a_event: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && arrival_event |-> nav_status == gad_pkg::ST_ARRIVED)
		else $error("arrival event without arrival");

	// Waiting items carry no distance.
	a_wait_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (nav_status == gad_pkg::ST_WAIT_FIX
			|| nav_status == gad_pkg::ST_WAIT_DEST) |-> distance_cm == 31'd0)
		else $error("distance reported while waiting");

	a_dist_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> distance_cm <= gad_pkg::DIST_MAX[30:0])
		else $error("distance beyond half the circumference");

endmodule

bind gnss_arrival_distance_core gad_checker u_gad_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.distance_cm   (res.distance_cm),
	.nav_status    (res.nav_status),
	.stop_request  (res.stop_request),
	.arrival_event (res.arrival_event)
);

`default_nettype wire
